[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising aclk out of reset
`define ALPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising aclk out of reset
`define ALPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Invariant that holds at every rising aclk out of reset
`define ALPS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("invariant check failed");

`endif

[hdl/alps_pkg.sv]
// Package: shared types and constants of the LED pulse serializer.
package alps_pkg;

    // Width of the bit-period tick counter
    localparam int TICK_COUNT_BITS = 16;
    // Compare width: covers both the counter and the 16-bit timing registers
    localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
    // Longest period the counter can time
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({TICK_COUNT_BITS{1'b1}});

    // Bits sent per colour byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Register reset values
    localparam logic [7:0]  BRIGHTNESS_RST = 8'd32;
    localparam logic [15:0] HIGH_ONE_RST   = 16'd64;
    localparam logic [15:0] HIGH_ZERO_RST  = 16'd32;
    localparam logic [15:0] PERIOD_RST     = 16'd100;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_HIGH_ONE   = 2'd1,
        REG_HIGH_ZERO  = 2'd2,
        REG_PERIOD     = 2'd3
    } reg_idx_t;

    // Input item kind, carried on tuser
    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    // Configuration register bank
    typedef struct packed {
        logic [7:0]  brightness;
        logic [15:0] high_one;
        logic [15:0] high_zero;
        logic [15:0] period;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic done;
        logic need;
        logic pin;
    } res_t;

    // Core status for checking
    typedef struct packed {
        logic busy;
        logic bits_nonzero;
    } core_status_t;

endpackage

[hdl/alps_cfg_regs.sv]
// Configuration register bank written through the plain write port.
module alps_cfg_regs
    import alps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_BRIGHTNESS: cfg_next.brightness = cfg_wdata[7:0];
                REG_HIGH_ONE:   cfg_next.high_one   = cfg_wdata;
                REG_HIGH_ZERO:  cfg_next.high_zero  = cfg_wdata;
                REG_PERIOD:     cfg_next.period     = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.brightness <= BRIGHTNESS_RST;
            cfg_reg.high_one   <= HIGH_ONE_RST;
            cfg_reg.high_zero  <= HIGH_ZERO_RST;
            cfg_reg.period     <= PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/alps_core.sv]
// Serializer state and per-transaction update: byte load, tick timing, pin level.
module alps_core
    import alps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         in_fire,
    input  logic         in_func,
    input  logic [7:0]   in_color_byte,
    input  logic         in_last_byte,
    output logic         res_valid,
    output res_t         res,
    output core_status_t status
);

    logic [7:0]                 shift_reg,  shift_next;
    logic [3:0]                 bits_reg,   bits_next;
    logic [TICK_COUNT_BITS-1:0] tick_reg,   tick_next;
    logic                       busy_reg,   busy_next;
    logic                       fe_reg,     fe_next;

    logic [15:0]                product;
    logic [CMP_W-1:0]           period_eff;
    logic [CMP_W-1:0]           high_eff;
    logic [TICK_COUNT_BITS-1:0] tick_inc;
    logic [3:0]                 bits_dec;

    // Brightness scaling of the incoming byte
    assign product = 16'(in_color_byte) * 16'(cfg.brightness);

    // Effective period: zero counts as one, clipped to the counter range
    always_comb begin
        period_eff = CMP_W'(cfg.period);
        if (period_eff == '0) begin
            period_eff = CMP_W'(1);
        end
        if (period_eff > CNT_MAX) begin
            period_eff = CNT_MAX;
        end
    end

    // High time of the current bit, clipped to the period
    always_comb begin
        high_eff = shift_reg[7] ? CMP_W'(cfg.high_one) : CMP_W'(cfg.high_zero);
        if (high_eff > period_eff) begin
            high_eff = period_eff;
        end
    end

    assign tick_inc = tick_reg + TICK_COUNT_BITS'(1);
    assign bits_dec = bits_reg - 4'd1;

    // State update and result for one transaction
    always_comb begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        tick_next  = tick_reg;
        busy_next  = busy_reg;
        fe_next    = fe_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (in_fire) begin
            if (func_t'(in_func) == FUNC_BYTE) begin
                // a byte offered while busy is dropped
                if (!busy_reg) begin
                    shift_next = product[15:8];
                    bits_next  = BITS_PER_BYTE;
                    tick_next  = '0;
                    busy_next  = 1'b1;
                    fe_next    = in_last_byte;
                end
            end else begin
                res_valid = 1'b1;
                if (busy_reg) begin
                    res.pin = (CMP_W'(tick_reg) < high_eff);
                    if (CMP_W'(tick_inc) >= period_eff) begin
                        // end of bit period: next bit
                        tick_next  = '0;
                        shift_next = {shift_reg[6:0], 1'b0};
                        bits_next  = bits_dec;
                        if (bits_dec == '0) begin
                            busy_next = 1'b0;
                            if (fe_reg) begin
                                res.done = 1'b1;
                                fe_next  = 1'b0;
                            end
                        end
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                res.need = !busy_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            bits_reg  <= '0;
            tick_reg  <= '0;
            busy_reg  <= 1'b0;
            fe_reg    <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            tick_reg  <= tick_next;
            busy_reg  <= busy_next;
            fe_reg    <= fe_next;
        end
    end

    assign status.busy         = busy_reg;
    assign status.bits_nonzero = (bits_reg != '0);

endmodule

[hdl/alps_out_reg.sv]
// Result register between the core and the master stream port.
module alps_out_reg
    import alps_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic valid_reg, valid_next;
    res_t res_reg,   res_next;

    // Free when empty or when the held transaction leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next = in_valid;
            res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[hdl/addressable_led_pulse_serializer.sv]
// Top level of the addressable LED pulse serializer.
// The block takes one transaction per clock: a colour byte (tuser 0) or one
// tick of the pulse timer (tuser 1). Each tick yields one result transaction
// with the pin level for that tick, whether a new byte can be taken, and (on
// tlast) the end of the last bit of a byte marked last; byte offers yield no
// result and are dropped while a byte is still being sent. A transaction's
// work is done combinationally between the serializer state and a one-deep
// result register, so the input accepts every cycle; s_axis_tready drops only
// while that result register is full and m_axis_tready is low. A result
// appears in the cycle after its tick is accepted. Configuration writes take
// effect at once and are meant to be done while the block is idle.
`include "assert_macros.svh"

module addressable_led_pulse_serializer
    import alps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] color_byte
    input  logic        s_axis_tuser,   // [0] func
    input  logic        s_axis_tlast,   // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] pin_level, [1] need_byte, [7:2] zero
    output logic        m_axis_tlast    // frame_done
);

    cfg_t         cfg;
    logic         in_fire;
    logic         core_res_valid;
    res_t         core_res;
    res_t         out_res;
    core_status_t core_status;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    alps_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    alps_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_fire       (in_fire),
        .in_func       (s_axis_tuser),
        .in_color_byte (s_axis_tdata),
        .in_last_byte  (s_axis_tlast),
        .res_valid     (core_res_valid),
        .res           (core_res),
        .status        (core_status)
    );

    alps_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (core_res_valid),
        .in_res    (core_res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    // Result packing
    assign m_axis_tdata = {6'b0, out_res.need, out_res.pin};
    assign m_axis_tlast = out_res.done;

    // Busy exactly while bits remain to be sent
    `ALPS_ASSERT_ALWAYS(a_busy_bits, core_status.busy == core_status.bits_nonzero)
    // A frame end is only reported once the shifter is free
    `ALPS_ASSERT_IMP(a_done_need, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1])
    // A tick taken while idle gives a low pin and a byte request next cycle
    `ALPS_ASSERT_NEXT(a_idle_tick,
        in_fire && (s_axis_tuser == FUNC_TICK) && !core_status.busy,
        m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[1] && !m_axis_tlast)

endmodule
